// ===== rtl/itfrx_pkg.sv =====
// ----------------------------------------------------------------------------
// itfrx_pkg
// Shared types and constants for the idle-timeout frame receive FIFO.
// ----------------------------------------------------------------------------
package itfrx_pkg;

	// ring geometry
	localparam int RING_DEPTH = 64;
	localparam int PTR_W      = $clog2(RING_DEPTH);

	// field widths
	localparam int BYTE_W = 8;
	localparam int TMO_W  = 6;
	localparam int IDLE_W = 6;
	localparam int CNT_W  = 7;
	localparam int CMD_W  = 2;

	// limits and reset values
	localparam logic [IDLE_W-1:0] IDLE_MAX    = 6'h3f;
	localparam logic [CNT_W-1:0]  MAX_POP     = 7'h40;
	localparam logic [TMO_W-1:0]  TIMEOUT_RST = 6'd3;

	// command codes carried on the input tuser
	localparam logic [CMD_W-1:0] CMD_BYTE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic wr_byte;    // store rx byte, restart idle count
		logic tick;       // advance idle count
		logic start_read; // latch pop limit, clear pop count
		logic fetch;      // read ring at read pointer
		logic load;       // move fetched byte into output register, pop
		logic empty_res;  // load the nothing-to-pop result
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic can_pop;    // frame done, limit nonzero, ring not empty
		logic out_last;   // output register holds the final beat of a read
	} dp_stat_t;

	// ring pointer increment with wrap
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/itfrx_dpath.sv =====
// ----------------------------------------------------------------------------
// itfrx_dpath
// Ring memory, pointers, frame status, idle counter and output register.
// ----------------------------------------------------------------------------
module itfrx_dpath
	import itfrx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TMO_W-1:0]  cfg_wdata,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [CNT_W-1:0]  read_max,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	output logic [BYTE_W-1:0] out_data,
	output logic              out_flag,
	output logic              out_last,
	output logic [CNT_W-1:0]  out_count
);

	logic [BYTE_W-1:0] ring_q [RING_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic [PTR_W-1:0]  wptr_q, rptr_q;
	logic              full_q, recv_q, done_q;
	logic [IDLE_W-1:0] idle_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [CNT_W-1:0]  want_q, count_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_flag_q, out_last_q;
	logic [CNT_W-1:0]  out_count_q;

	logic              empty;
	logic [PTR_W-1:0]  wptr_nx, rptr_nx;
	logic [IDLE_W-1:0] idle_inc;
	logic [CNT_W-1:0]  count_inc;
	logic              pop_last;
	logic              byte_in;

	// next-value helpers
	assign empty     = (rptr_q == wptr_q) && !full_q;
	assign wptr_nx   = ptr_next(wptr_q);
	assign rptr_nx   = ptr_next(rptr_q);
	assign idle_inc  = (idle_q < IDLE_MAX) ? idle_q + 1'b1 : idle_q;
	assign count_inc = count_q + 1'b1;
	assign pop_last  = (count_inc == want_q) || (rptr_nx == wptr_q);
	assign byte_in   = cmd.wr_byte && !done_q;

	// ring memory write and registered read
	always_ff @(posedge clk) begin
		if (byte_in) begin
			ring_q[wptr_q] <= rx_byte;
		end
		if (cmd.fetch) begin
			rdata_q <= ring_q[rptr_q];
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// pointers and frame status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			full_q <= 1'b0;
			recv_q <= 1'b0;
			done_q <= 1'b0;
			idle_q <= '0;
		end else begin
			if (byte_in) begin
				wptr_q <= wptr_nx;
				// full ring drops its oldest byte
				if (wptr_nx == rptr_q) begin
					rptr_q <= rptr_nx;
					full_q <= 1'b1;
				end
				recv_q <= 1'b1;
				idle_q <= '0;
			end
			if (cmd.tick && recv_q) begin
				idle_q <= idle_inc;
				if (idle_inc > timeout_q) begin
					done_q <= 1'b1;
				end
			end
			if (cmd.load) begin
				rptr_q <= rptr_nx;
				full_q <= 1'b0;
			end
			// status clears at the end of a read of a done frame
			if ((cmd.load && pop_last) || (cmd.empty_res && done_q)) begin
				recv_q <= 1'b0;
				done_q <= 1'b0;
				idle_q <= '0;
			end
		end
	end

	// pop limit and pop count
	always_ff @(posedge clk) begin
		if (cmd.start_read) begin
			want_q  <= (read_max > MAX_POP) ? MAX_POP : read_max;
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_inc;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_data_q  <= rdata_q;
			out_flag_q  <= 1'b1;
			out_last_q  <= pop_last;
			out_count_q <= count_inc;
		end else if (cmd.empty_res) begin
			out_data_q  <= '0;
			out_flag_q  <= 1'b0;
			out_last_q  <= 1'b1;
			out_count_q <= '0;
		end
	end

	assign stat.can_pop  = done_q && (want_q != '0) && !empty;
	assign stat.out_last = out_last_q;

	assign out_data  = out_data_q;
	assign out_flag  = out_flag_q;
	assign out_last  = out_last_q;
	assign out_count = out_count_q;

endmodule

// ===== rtl/itfrx_ctrl.sv =====
// ----------------------------------------------------------------------------
// itfrx_ctrl
// Controller: input handshake, read sequencing and output valid.
// ----------------------------------------------------------------------------
module itfrx_ctrl
	import itfrx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] command,
	output logic             in_ready,
	input  logic             out_ready,
	output logic             out_valid,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_SEND
	} state_t;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   acc;

	assign acc      = (state_q == ST_IDLE) && in_valid;
	assign in_ready = (state_q == ST_IDLE);

	// commands and next state
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (command)
						CMD_BYTE: cmd.wr_byte = 1'b1;
						CMD_TICK: cmd.tick    = 1'b1;
						CMD_READ: begin
							cmd.start_read = 1'b1;
							state_nx       = ST_CHECK;
						end
						default: ;
					endcase
				end
			end
			ST_CHECK: begin
				if (stat.can_pop) begin
					cmd.fetch = 1'b1;
					state_nx  = ST_LOAD;
				end else begin
					cmd.empty_res = 1'b1;
					state_nx      = ST_SEND;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_nx = ST_SEND;
			end
			ST_SEND: begin
				if (out_ready) begin
					if (stat.out_last) begin
						state_nx = ST_IDLE;
					end else begin
						cmd.fetch = 1'b1;
						state_nx  = ST_LOAD;
					end
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= (state_nx == ST_SEND);
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/idle_timeout_frame_rx_fifo_core.sv =====
// Idle-timeout frame receive FIFO. Byte arrivals and timer ticks are accepted
// back to back while no read is in progress. A read request first checks
// status in ST_CHECK. Each popped byte is then fetched by the registered ring
// memory read, moved into the output register in ST_LOAD, and presented in
// ST_SEND for as long as the downstream holds tready low. A read with nothing
// to pop gives a single beat. No new item is accepted until the last beat of
// a read is taken. The ring needs no clearing pass after reset.
// ----------------------------------------------------------------------------
// idle_timeout_frame_rx_fifo_core
// Ring buffer of received bytes; a frame is done after an idle timeout and
// is then popped byte by byte on a read request.
// ----------------------------------------------------------------------------
module idle_timeout_frame_rx_fifo_core
	import itfrx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration: idle_timeout_ticks
	input  logic              cfg_we,
	input  logic [TMO_W-1:0]  cfg_wdata,
	// input stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,  // rx_byte[7:0], read_max[14:8], zero
	input  logic [CMD_W-1:0]  s_axis_tuser,  // command[1:0]
	// output stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // data_byte[7:0], bytes_read[14:8], zero
	output logic              m_axis_tuser,  // byte_valid
	output logic              m_axis_tlast
);

	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [BYTE_W-1:0] out_data;
	logic              out_flag;
	logic              out_last;
	logic [CNT_W-1:0]  out_count;

	// read sequencing
	itfrx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.command   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and status
	itfrx_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_byte   (s_axis_tdata[7:0]),
		.read_max  (s_axis_tdata[14:8]),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data),
		.out_flag  (out_flag),
		.out_last  (out_last),
		.out_count (out_count)
	);

	// output packing
	assign m_axis_tdata = {1'b0, out_count, out_data};
	assign m_axis_tuser = out_flag;
	assign m_axis_tlast = out_last;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the idle-timeout frame receive FIFO: byte, tick and
// read beats go in under random flow control, and every popped beat is
// compared field by field against a scoreboard that tracks ring and status.
// ----------------------------------------------------------------------------
module testbench;
	import itfrx_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
	localparam int               HOLD_CYCLES    = 300;
	localparam int               WATCHDOG_LIMIT = 4000;
	localparam int               SETTLE_CYCLES  = 4;

	// one expected output beat
	typedef struct {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              last;
		logic [CNT_W-1:0]  bytes_read;
	} pop_beat_t;

	// ring and status tracker with the queue of expected pop beats
	class rx_frame_scoreboard;
		logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
		logic [PTR_W-1:0]  wr_ptr;
		logic [PTR_W-1:0]  rd_ptr;
		logic              ring_is_full;
		logic              in_frame;
		logic              frame_ready;
		logic [IDLE_W-1:0] idle_ticks;
		logic [TMO_W-1:0]  timeout;
		pop_beat_t         pop_queue [$];
		int                errors;

		function new();
			wr_ptr       = '0;
			rd_ptr       = '0;
			ring_is_full = 1'b0;
			in_frame     = 1'b0;
			frame_ready  = 1'b0;
			idle_ticks   = '0;
			timeout      = TIMEOUT_RST;
			errors       = 0;
		endfunction

		function logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
			return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
		endfunction

		function void set_timeout(logic [TMO_W-1:0] v);
			timeout = v;
		endfunction

		function int pending();
			return pop_queue.size();
		endfunction

		// advance the tracked state by one accepted input beat
		function void note_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] rx,
				logic [CNT_W-1:0] want);
			pop_beat_t b;
			int        limit;
			int        n;
			case (cmd)
				CMD_BYTE: begin
					if (!frame_ready) begin
						ring_bytes[wr_ptr] = rx;
						wr_ptr = wrap_inc(wr_ptr);
						// full ring drops its oldest byte
						if (wr_ptr == rd_ptr) begin
							rd_ptr       = wrap_inc(rd_ptr);
							ring_is_full = 1'b1;
						end
						in_frame   = 1'b1;
						idle_ticks = '0;
					end
				end
				CMD_TICK: begin
					if (in_frame) begin
						if (idle_ticks < IDLE_MAX)
							idle_ticks = idle_ticks + 1'b1;
						if (idle_ticks > timeout)
							frame_ready = 1'b1;
					end
				end
				CMD_READ: begin
					limit = (want > MAX_POP) ? int'(MAX_POP) : int'(want);
					n = 0;
					if (frame_ready) begin
						while (n < limit && !(rd_ptr == wr_ptr && !ring_is_full)) begin
							b.data_byte  = ring_bytes[rd_ptr];
							b.byte_valid = 1'b1;
							b.last       = 1'b0;
							b.bytes_read = CNT_W'(n + 1);
							pop_queue.push_back(b);
							rd_ptr       = wrap_inc(rd_ptr);
							ring_is_full = 1'b0;
							n++;
						end
						in_frame    = 1'b0;
						frame_ready = 1'b0;
						idle_ticks  = '0;
					end
					// nothing popped gives a single empty beat
					if (n == 0) begin
						b.data_byte  = '0;
						b.byte_valid = 1'b0;
						b.last       = 1'b1;
						b.bytes_read = '0;
						pop_queue.push_back(b);
					end else begin
						pop_queue[pop_queue.size() - 1].last = 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		// compare one accepted output beat with the oldest expectation
		function void check_beat(logic [BYTE_W-1:0] data_byte, logic byte_valid,
				logic last, logic [CNT_W-1:0] bytes_read);
			pop_beat_t e;
			if (pop_queue.size() == 0) begin
				$error("unexpected output beat: data_byte %0d", data_byte);
				errors++;
				return;
			end
			e = pop_queue.pop_front();
			if (data_byte !== e.data_byte) begin
				$error("data_byte: expected %0d, got %0d", e.data_byte, data_byte);
				errors++;
			end
			if (byte_valid !== e.byte_valid) begin
				$error("byte_valid: expected %0d, got %0d", e.byte_valid, byte_valid);
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, last);
				errors++;
			end
			if (bytes_read !== e.bytes_read) begin
				$error("bytes_read: expected %0d, got %0d", e.bytes_read, bytes_read);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [TMO_W-1:0]  cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata;  // rx_byte[7:0], read_max[14:8], zero
	logic [CMD_W-1:0]  s_axis_tuser;  // command[1:0]
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [15:0]       m_axis_tdata;  // data_byte[7:0], bytes_read[14:8], zero
	logic              m_axis_tuser;  // byte_valid
	logic              m_axis_tlast;

	rx_frame_scoreboard sb = new();

	logic              calm = 1'b0;
	int                hold_req = 0;
	int                items_sent = 0;
	int                idle_cycles = 0;
	logic [TMO_W-1:0]  cur_timeout = TIMEOUT_RST;

	idle_timeout_frame_rx_fifo_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// beat monitor, scoreboard hookup and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_beat(m_axis_tdata[7:0], m_axis_tuser, m_axis_tlast,
					m_axis_tdata[14:8]);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[14:8]);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[idle_timeout_frame_rx_fifo_core] ERROR");
				$finish;
			end
		end
	end

	// downstream ready: random stalls, plus one long hold-off on request
	initial begin
		int hold_ack;
		hold_ack = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ack != hold_req) begin
				hold_ack = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	// offer one input beat, with random gaps, until it is taken
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] rx,
			input logic [CNT_W-1:0] want);
		while (!calm && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {1'b0, want, rx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering and wait for every expected beat, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TMO_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_timeout(v);
		cur_timeout = v;
	endtask

	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_item(CMD_TICK, BYTE_W'($urandom), CNT_W'($urandom));
	endtask

	// bytes, idle ticks past the timeout, then a read; some frames are broken
	task automatic send_frame();
		int r;
		int nbytes;
		int nticks;
		logic [CNT_W-1:0] want;
		r = $urandom_range(0, 99);
		if (r < 10)
			nbytes = $urandom_range(60, 80);
		else if (r < 15)
			nbytes = 0;
		else
			nbytes = $urandom_range(1, 16);
		for (int i = 0; i < nbytes; i++)
			send_item(CMD_BYTE, BYTE_W'($urandom), CNT_W'($urandom));
		if ($urandom_range(0, 99) < 15)
			nticks = $urandom_range(0, cur_timeout);
		else
			nticks = int'(cur_timeout) + 1 + $urandom_range(0, 3);
		send_ticks(nticks);
		// late bytes after the frame is done are dropped
		if ($urandom_range(0, 99) < 15) begin
			for (int i = 0; i < $urandom_range(1, 3); i++)
				send_item(CMD_BYTE, BYTE_W'($urandom), CNT_W'($urandom));
		end
		r = $urandom_range(0, 99);
		if (r < 10)
			want = '0;
		else if (r < 25)
			want = CNT_W'($urandom_range(65, 127));
		else
			want = CNT_W'($urandom_range(1, 64));
		send_item(CMD_READ, BYTE_W'($urandom), want);
		if ($urandom_range(0, 99) < 10)
			send_item(CMD_READ, BYTE_W'($urandom), CNT_W'($urandom));
	endtask

	// mostly well-formed frames, the rest random beats of any command
	task automatic run_random(input int n);
		int start;
		start = items_sent;
		while (items_sent - start < n) begin
			if ($urandom_range(0, 99) < 20)
				send_item(CMD_W'($urandom_range(0, 3)), BYTE_W'($urandom),
					CNT_W'($urandom));
			else
				send_frame();
		end
	endtask

	// stimulus
	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_BYTE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset timeout of 3
		send_item(CMD_READ, 8'h00, 7'd5);        // read with no frame done
		send_item(CMD_TICK, 8'h00, 7'd0);        // tick while not receiving
		send_item(CMD_UNUSED, 8'hff, 7'h7f);     // unused command
		send_item(CMD_BYTE, 8'h00, 7'h7f);
		send_item(CMD_BYTE, 8'hff, 7'h00);
		send_item(CMD_BYTE, 8'ha5, 7'h2a);
		send_ticks(4);
		send_item(CMD_BYTE, 8'h5a, 7'h55);       // byte while frame done
		send_item(CMD_READ, 8'hff, 7'd0);        // zero limit, clears status
		send_item(CMD_TICK, 8'hff, 7'h7f);
		send_item(CMD_BYTE, 8'h3c, 7'd1);
		send_ticks(4);
		send_item(CMD_READ, 8'h00, 7'd127);      // limit above 64
		send_item(CMD_READ, 8'h00, 7'd64);
		drain();

		// timeout 0, with a long downstream hold-off while beats keep coming
		write_timeout(6'd0);
		hold_req = hold_req + 1;
		run_random(110);
		drain();

		// timeout 63: the idle count saturates and no frame ever completes
		write_timeout(6'd63);
		for (int i = 0; i < 3; i++)
			send_item(CMD_BYTE, BYTE_W'($urandom), CNT_W'($urandom));
		send_ticks(70);
		send_item(CMD_READ, 8'h00, 7'd64);
		drain();

		// timeout 62 with no idling on either side
		write_timeout(6'd62);
		calm = 1'b1;
		run_random(130);
		drain();
		calm = 1'b0;

		// small random timeout
		write_timeout(TMO_W'($urandom_range(1, 8)));
		run_random(110);
		drain();

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[idle_timeout_frame_rx_fifo_core] OK");
		else
			$display("[idle_timeout_frame_rx_fifo_core] ERROR");
		$finish;
	end

endmodule

// ===== idle_timeout_frame_rx_fifo_core.f =====
rtl/itfrx_pkg.sv
rtl/itfrx_dpath.sv
rtl/itfrx_ctrl.sv
rtl/idle_timeout_frame_rx_fifo_core.sv
tb/sv/testbench.sv
